### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the matrix multiply engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property check, disabled while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// The expression must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### sv/mme_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Types, codes and default sizes shared by the engine files.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int PROD_W      = 2 * DATA_W;

	// Command kinds.
	localparam logic [1:0] KIND_LOAD_A  = 2'd0;
	localparam logic [1:0] KIND_LOAD_B  = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;

	// Configuration register indexes.
	localparam int          CFG_IDX_W    = 2;
	localparam int          CFG_DATA_W   = 4;
	localparam logic [1:0]  REG_ROWS_A   = 2'd0;
	localparam logic [1:0]  REG_INNER    = 2'd1;
	localparam logic [1:0]  REG_COLS_B   = 2'd2;
	localparam logic [3:0]  DIM_RESET    = 4'd8;

	typedef struct packed {
		logic [1:0]               kind;
		logic [2:0]               row_index;
		logic [2:0]               col_index;
		logic signed [DATA_W-1:0] element_value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]               out_row;
		logic [2:0]               out_col;
		logic signed [DATA_W-1:0] out_value;
		logic                     last;
	} res_t;

	// Tag that travels with each product through the multiply-accumulate pipe.
	typedef struct packed {
		logic       first;
		logic       fin;
		logic [2:0] row;
		logic [2:0] col;
		logic       last;
	} mac_tag_t;

	typedef enum logic {
		ST_IDLE,
		ST_ISSUE
	} issue_state_t;

endpackage

### sv/mme_chan_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface mme_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/matrix_multiply_engine_core.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Loads A and B element by element into two RAMs and streams C = A * B.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word     Meaning
//  cmd      in         cmd_t    load an element of A or B, or start a product
//  res      out        res_t    one element of C, row-major, last on the final
//  cfg_*    in         4 bits   rows_a, inner_dim, cols_b (write only)
//
// A load is written to its RAM as it is accepted. A compute word issues
// rows * cols * inner reads, one per cycle from each RAM while res is not held,
// into the single multiply-accumulate unit; the last element leaves through
// the read, product, accumulator and output registers. cmd is held off only
// while reads are being issued; loads are taken again while the tail of a
// product still drains. A held result on res freezes the read and multiply
// pipeline. Reset clears control only; the RAMs hold garbage until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_multiply_engine_core import mme_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mme_chan_if.sink              cmd,
	mme_chan_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);

	logic [CFG_DATA_W-1:0] rows_a_q;
	logic [CFG_DATA_W-1:0] inner_q;
	logic [CFG_DATA_W-1:0] cols_b_q;

	issue_state_t state_q;
	issue_state_t state_d;

	logic [IDX_W-1:0] r_q;
	logic [IDX_W-1:0] c_q;
	logic [IDX_W-1:0] k_q;

	logic [DIM_W-1:0] nr_m1;
	logic [DIM_W-1:0] nc_m1;
	logic [DIM_W-1:0] nk_m1;

	logic             adv;
	logic             cmd_fire;
	logic             ld_ok;
	logic             we_a;
	logic             we_b;
	logic [ADDR_W-1:0] waddr;
	logic             issue_en;
	logic             k_end;
	logic             c_end;
	logic             r_end;
	logic             cnt_in_range;
	logic [ADDR_W-1:0] raddr_a;
	logic [ADDR_W-1:0] raddr_b;
	mac_tag_t         tag_issue;

	logic             vld_s1;
	mac_tag_t         tag_s1;
	logic [DATA_W-1:0] a_rd;
	logic [DATA_W-1:0] b_rd;

	logic             fin_valid;
	res_t             fin_data;
	logic             res_vld_q;
	res_t             res_data_q;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			return DIM_W'(MAX_DIM);
		end
		return DIM_W'(v);
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= DIM_RESET;
			inner_q  <= DIM_RESET;
			cols_b_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROWS_A: rows_a_q <= cfg_data;
				REG_INNER:  inner_q  <= cfg_data;
				REG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign nr_m1 = clamp_dim(rows_a_q) - DIM_W'(1);
	assign nk_m1 = clamp_dim(inner_q) - DIM_W'(1);
	assign nc_m1 = clamp_dim(cols_b_q) - DIM_W'(1);

	// The whole pipeline moves unless a finished word is waiting on res.
	assign adv      = !res_vld_q || res.ready;
	assign cmd_fire = cmd.valid && cmd.ready;

	// Loads outside the stored matrix size are dropped.
	assign ld_ok = (int'(cmd.data.row_index) < MAX_DIM) &&
		(int'(cmd.data.col_index) < MAX_DIM);
	assign we_a  = cmd_fire && ld_ok && (cmd.data.kind == KIND_LOAD_A);
	assign we_b  = cmd_fire && ld_ok && (cmd.data.kind == KIND_LOAD_B);
	assign waddr = ADDR_W'(cmd.data.row_index) * ADDR_W'(MAX_DIM) +
		ADDR_W'(cmd.data.col_index);

	assign k_end = (DIM_W'(k_q) == nk_m1);
	assign c_end = (DIM_W'(c_q) == nc_m1);
	assign r_end = (DIM_W'(r_q) == nr_m1);

	assign cnt_in_range = (DIM_W'(k_q) <= nk_m1) && (DIM_W'(c_q) <= nc_m1) &&
		(DIM_W'(r_q) <= nr_m1);

	// Issue state machine: next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && (cmd.data.kind == KIND_COMPUTE)) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (adv && k_end && c_end && r_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Issue state machine: outputs.
	always_comb begin
		cmd.ready = 1'b0;
		issue_en  = 1'b0;
		case (state_q)
			ST_IDLE:  cmd.ready = 1'b1;
			ST_ISSUE: issue_en  = adv;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				vld_s1 <= issue_en;
			end
			// Inner index runs fastest, then column, then row; all wrap to zero.
			if (issue_en) begin
				if (k_end) begin
					k_q <= '0;
					if (c_end) begin
						c_q <= '0;
						r_q <= r_end ? '0 : r_q + IDX_W'(1);
					end else begin
						c_q <= c_q + IDX_W'(1);
					end
				end else begin
					k_q <= k_q + IDX_W'(1);
				end
			end
		end
	end

	assign raddr_a = ADDR_W'(r_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
	assign raddr_b = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(c_q);

	always_comb begin
		tag_issue.first = (k_q == '0);
		tag_issue.fin   = k_end;
		tag_issue.row   = 3'(r_q);
		tag_issue.col   = 3'(c_q);
		tag_issue.last  = r_end && c_end;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_issue;
		end
	end

	mme_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (cmd.data.element_value),
		.re    (issue_en),
		.raddr (raddr_a),
		.rdata (a_rd)
	);

	mme_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (cmd.data.element_value),
		.re    (issue_en),
		.raddr (raddr_b),
		.rdata (b_rd)
	);

	mme_mac #(
		.MAX_DIM (MAX_DIM)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s1),
		.a_data    ($signed(a_rd)),
		.b_data    ($signed(b_rd)),
		.in_tag    (tag_s1),
		.fin_valid (fin_valid),
		.fin_data  (fin_data)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin_valid) begin
			res_data_q <= fin_data;
		end
	end

	assign res.valid = res_vld_q;
	assign res.data  = res_data_q;

	`ASSERT_NEVER(a_no_load_during_issue, clk, arst_n, issue_en && (we_a || we_b))
	`ASSERT_PROP(a_issue_in_bounds, clk, arst_n, (state_q == ST_ISSUE) |-> cnt_in_range)
	`ASSERT_PROP(a_result_from_mac, clk, arst_n, $rose(res_vld_q) |-> $past(fin_valid))

endmodule

### sv/mme_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/mme_mac.sv
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Signed 32x32 multiply, exact accumulation, shift and saturation to Q16.16.
// ----------------------------------------------------------------------------
module mme_mac import mme_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  logic signed [DATA_W-1:0] a_data,
	input  logic signed [DATA_W-1:0] b_data,
	input  mac_tag_t                 in_tag,
	output logic                     fin_valid,
	output res_t                     fin_data
);

	// Each product fits in 64 signed bits, so the sum needs log2 of the count more.
	localparam int ACC_W = PROD_W + $clog2(MAX_DIM);
	localparam int TOP_W = ACC_W - FRAC_BITS - DATA_W + 1;

	logic                     vld_s2;
	logic                     vld_s3;
	logic signed [PROD_W-1:0] prod_s2;
	mac_tag_t                 tag_s2;
	mac_tag_t                 tag_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic [TOP_W-1:0]         top_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= in_valid;
			vld_s3 <= vld_s2 && tag_s2.fin;
		end
	end

	assign prod_ext = ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= a_data * b_data;
			tag_s2  <= in_tag;
			tag_s3  <= tag_s2;
			if (vld_s2) begin
				acc_q <= tag_s2.first ? prod_ext : acc_q + prod_ext;
			end
		end
	end

	// The shifted sum fits in 32 bits only if all bits from 47 upward agree.
	assign top_bits = acc_q[ACC_W-1:FRAC_BITS+DATA_W-1];

	always_comb begin
		fin_valid          = vld_s3;
		fin_data.out_row   = tag_s3.row;
		fin_data.out_col   = tag_s3.col;
		fin_data.last      = tag_s3.last;
		if ((&top_bits) || !(|top_bits)) begin
			fin_data.out_value = acc_q[FRAC_BITS+DATA_W-1:FRAC_BITS];
		end else if (acc_q[ACC_W-1]) begin
			fin_data.out_value = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			fin_data.out_value = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

endmodule

### sim/matrix_multiply_engine_core_tb.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine testbench
// Loads A and B element by element, starts products under a range of
// dimension settings and checks every element of C against a predictor
// kept in step with each accepted command word.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_core_tb import mme_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          MAX_DIM        = MAX_DIM_DEF;
	localparam logic [1:0]  KIND_UNUSED    = 2'd3;
	localparam logic [1:0]  REG_UNUSED     = 2'd3;
	localparam int          RANDOM_ITEMS   = 380;
	localparam int          DRAIN_CYCLES   = 16;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          REPORT_LIMIT   = 10;
	localparam logic signed [71:0] Q_MAX   = 72'sh7FFF_FFFF;
	localparam logic signed [71:0] Q_MIN   = -72'sh8000_0000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	mme_chan_if #(.T(cmd_t)) cmd_ch ();
	mme_chan_if #(.T(res_t)) res_ch ();

	matrix_multiply_engine_core #(.MAX_DIM(MAX_DIM)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Predictor state: both matrices, which entries hold data, and the registers.
	logic signed [DATA_W-1:0] mat_a [MAX_DIM][MAX_DIM];
	logic signed [DATA_W-1:0] mat_b [MAX_DIM][MAX_DIM];
	bit                       a_loaded [MAX_DIM][MAX_DIM];
	bit                       b_loaded [MAX_DIM][MAX_DIM];
	logic [3:0]               dim_rows;
	logic [3:0]               dim_inner;
	logic [3:0]               dim_cols;

	res_t expected_c[$];
	int   items_sent;
	int   error_count;
	bit   steady;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int eff_dim(input logic [3:0] v);
		if (v == 4'd0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	// Exact sum over the inner dimension, floor-shifted to Q16.16 and saturated.
	function automatic logic signed [DATA_W-1:0] dot_q16(input int r, input int c,
			input int n);
		logic signed [71:0] acc;
		logic signed [71:0] scaled;
		acc = '0;
		for (int k = 0; k < n; k++)
			acc = acc + mat_a[r][k] * mat_b[k][c];
		scaled = acc >>> FRAC_BITS;
		if (scaled > Q_MAX)
			return 32'sh7FFF_FFFF;
		if (scaled < Q_MIN)
			return 32'sh8000_0000;
		return scaled[DATA_W-1:0];
	endfunction

	function automatic void apply_command(input cmd_t c);
		int   nr;
		int   ni;
		int   nc;
		res_t e;
		nr = eff_dim(dim_rows);
		ni = eff_dim(dim_inner);
		nc = eff_dim(dim_cols);
		case (c.kind)
			KIND_LOAD_A: begin
				mat_a[c.row_index][c.col_index] = c.element_value;
				a_loaded[c.row_index][c.col_index] = 1'b1;
			end
			KIND_LOAD_B: begin
				mat_b[c.row_index][c.col_index] = c.element_value;
				b_loaded[c.row_index][c.col_index] = 1'b1;
			end
			KIND_COMPUTE: begin
				for (int r = 0; r < nr; r++) begin
					for (int cc = 0; cc < nc; cc++) begin
						e.out_row   = 3'(r);
						e.out_col   = 3'(cc);
						e.out_value = dot_q16(r, cc, ni);
						e.last      = (r == nr - 1) && (cc == nc - 1);
						expected_c  = {expected_c, e};
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the next word can follow without a bubble.
	task automatic send_cmd(input logic [1:0] kind, input logic [2:0] row,
			input logic [2:0] col, input logic [31:0] value);
		cmd_t c;
		c.kind          = kind;
		c.row_index     = row;
		c.col_index     = col;
		c.element_value = value;
		while (!steady && $urandom_range(99) < 30) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		apply_command(c);
		if (kind != KIND_UNUSED)
			items_sent++;
		@(negedge clk);
	endtask

	// Stop sending and wait until the last expected element has arrived.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (expected_c.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Register writes leave the enable high between them; set_dims lowers it.
	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		case (idx)
			REG_ROWS_A: dim_rows  = val;
			REG_INNER:  dim_inner = val;
			REG_COLS_B: dim_cols  = val;
			default: ;
		endcase
	endtask

	task automatic set_dims(input logic [3:0] rows, input logic [3:0] inner,
			input logic [3:0] cols);
		write_reg(REG_ROWS_A, rows);
		write_reg(REG_INNER, inner);
		write_reg(REG_COLS_B, cols);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_q16();
		int v;
		case ($urandom_range(5))
			0: return $urandom();
			1: begin
				case ($urandom_range(5))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					4: return 32'h0001_0000;
					default: return 32'hFFFF_0000;
				endcase
			end
			default: begin
				v = $urandom_range(1 << 19);
				if ($urandom_range(1))
					v = -v;
				return 32'(v);
			end
		endcase
	endfunction

	function automatic logic [3:0] pick_dim();
		int p;
		p = $urandom_range(99);
		if (p < 60)
			return 4'($urandom_range(1, 3));
		if (p < 75)
			return 4'($urandom_range(4, 7));
		if (p < 85)
			return 4'd8;
		if (p < 92)
			return 4'd0;
		return 4'($urandom_range(9, 15));
	endfunction

	// Loads land mostly inside the active dimensions, sometimes anywhere.
	task automatic random_load();
		bit         to_a;
		logic [2:0] row;
		logic [2:0] col;
		int         nr;
		int         ni;
		int         nc;
		nr   = eff_dim(dim_rows);
		ni   = eff_dim(dim_inner);
		nc   = eff_dim(dim_cols);
		to_a = $urandom_range(1);
		if ($urandom_range(99) < 80) begin
			row = 3'($urandom_range(to_a ? nr - 1 : ni - 1));
			col = 3'($urandom_range(to_a ? ni - 1 : nc - 1));
		end else begin
			row = 3'($urandom_range(7));
			col = 3'($urandom_range(7));
		end
		if ($urandom_range(99) < 7)
			send_cmd(KIND_UNUSED, 3'($urandom_range(7)), 3'($urandom_range(7)), $urandom());
		send_cmd(to_a ? KIND_LOAD_A : KIND_LOAD_B, row, col, rand_q16());
	endtask

	// The RAMs come out of reset with garbage, so every entry a product reads
	// must be loaded first.
	task automatic load_missing();
		int nr;
		int ni;
		int nc;
		nr = eff_dim(dim_rows);
		ni = eff_dim(dim_inner);
		nc = eff_dim(dim_cols);
		for (int r = 0; r < nr; r++)
			for (int k = 0; k < ni; k++)
				if (!a_loaded[r][k])
					send_cmd(KIND_LOAD_A, 3'(r), 3'(k), rand_q16());
		for (int k = 0; k < ni; k++)
			for (int c = 0; c < nc; c++)
				if (!b_loaded[k][c])
					send_cmd(KIND_LOAD_B, 3'(k), 3'(c), rand_q16());
	endtask

	task automatic test_saturation();
		settle();
		set_dims(4'd1, 4'd2, 4'd2);
		send_cmd(KIND_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
		send_cmd(KIND_LOAD_A, 3'd0, 3'd1, 32'h7FFF_FFFF);
		send_cmd(KIND_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
		send_cmd(KIND_LOAD_B, 3'd1, 3'd0, 32'h7FFF_FFFF);
		send_cmd(KIND_LOAD_B, 3'd0, 3'd1, 32'h8000_0000);
		send_cmd(KIND_LOAD_B, 3'd1, 3'd1, 32'h8000_0000);
		send_cmd(KIND_COMPUTE, 3'd0, 3'd0, 32'h0);
	endtask

	// Zero dimensions act as one; floor rounding of negatives; corner indexes,
	// the unused command kind and the unused register index are harmless.
	task automatic test_minimum_dims();
		settle();
		write_reg(REG_UNUSED, 4'hF);
		set_dims(4'd0, 4'd0, 4'd0);
		send_cmd(KIND_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
		send_cmd(KIND_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
		send_cmd(KIND_UNUSED, 3'd7, 3'd7, $urandom());
		send_cmd(KIND_LOAD_A, 3'd7, 3'd7, 32'h8000_0000);
		send_cmd(KIND_LOAD_B, 3'd7, 3'd7, 32'h7FFF_FFFF);
		send_cmd(KIND_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
		send_cmd(KIND_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
		send_cmd(KIND_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
		send_cmd(KIND_COMPUTE, 3'd0, 3'd0, 32'h0);
		send_cmd(KIND_LOAD_A, 3'd0, 3'd0, 32'h0001_0000);
		send_cmd(KIND_LOAD_B, 3'd0, 3'd0, 32'hFFFE_8000);
		send_cmd(KIND_COMPUTE, 3'd0, 3'd0, 32'h0);
	endtask

	task automatic test_random_products();
		int first;
		int phase;
		first = items_sent;
		phase = 0;
		while (items_sent - first < RANDOM_ITEMS) begin
			settle();
			steady = (phase >= 4 && phase < 8);
			if (phase == 2)
				set_dims(4'd15, 4'd15, 4'd15);
			else
				set_dims(pick_dim(), pick_dim(), pick_dim());
			repeat ($urandom_range(1, 2)) begin
				repeat ($urandom_range(2, 12)) random_load();
				load_missing();
				send_cmd(KIND_COMPUTE, 3'($urandom_range(7)), 3'($urandom_range(7)),
					$urandom());
				// These loads may be taken while the product is still draining.
				repeat ($urandom_range(0, 3)) random_load();
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	always @(negedge clk)
		res_ch.ready <= steady || ($urandom_range(99) >= 30);

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_ch.data;
			if (expected_c.size() == 0) begin
				report_error($sformatf("unexpected word row %0d col %0d value %h last %b",
					got.out_row, got.out_col, got.out_value, got.last));
			end else begin
				want = expected_c.pop_front();
				if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
						got.out_value !== want.out_value || got.last !== want.last)
					report_error($sformatf(
						"expected row %0d col %0d value %h last %b, got row %0d col %0d value %h last %b",
						want.out_row, want.out_col, want.out_value, want.last,
						got.out_row, got.out_col, got.out_value, got.last));
			end
		end
	end

	// Ends the run if neither channel moves a word for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		res_ch.ready = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = REG_ROWS_A;
		cfg_data     = '0;
		dim_rows     = DIM_RESET;
		dim_inner    = DIM_RESET;
		dim_cols     = DIM_RESET;
		items_sent   = 0;
		error_count  = 0;
		steady       = 1'b0;
		for (int r = 0; r < MAX_DIM; r++)
			for (int c = 0; c < MAX_DIM; c++) begin
				mat_a[r][c]    = '0;
				mat_b[r][c]    = '0;
				a_loaded[r][c] = 1'b0;
				b_loaded[r][c] = 1'b0;
			end
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_saturation();
		test_minimum_dims();
		test_random_products();

		settle();
		if (expected_c.size() != 0)
			report_error($sformatf("%0d elements never arrived", expected_c.size()));
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
